// ===== src/signed_int_to_decimal_ascii_top_assert.svh =====
// Assertion macros shared by the checker of the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define SIDEC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decimal text converter: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define SIDEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decimal text converter: next-cycle check failed");

`endif

// ===== src/sidec_pkg.sv =====
// Types and constants of the signed integer to decimal text converter.
package sidec_pkg;

  typedef logic [3:0] digit_t;
  typedef logic [5:0] char_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  localparam char_t CHAR_ZERO  = 6'd48;
  localparam char_t CHAR_MINUS = 6'd45;

  // floor(n / 10) == (n * RECIP_TEN) >> RECIP_SHIFT for every 32-bit n
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam int MAX_DIGITS = 10;

endpackage

// ===== src/sidec_div10.sv =====
// Divide-by-ten unit: registered reciprocal product, quotient and remainder.
module sidec_div10 (
  input  logic              clk,
  input  logic              load,
  input  logic [31:0]       dividend,
  output logic [31:0]       quotient,
  output sidec_pkg::digit_t remainder
);
  import sidec_pkg::*;

  logic [63:0] prod;
  logic [31:0] q_times_ten;
  logic [31:0] diff;

  // Capture the product; dividend must hold until the remainder is taken.
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= {32'd0, dividend} * {32'd0, RECIP_TEN};
    end
  end

  assign quotient    = 32'(prod >> RECIP_SHIFT);
  assign q_times_ten = (quotient << 3) + (quotient << 1);
  assign diff        = dividend - q_times_ten;
  assign remainder   = diff[3:0];

endmodule

// ===== src/signed_int_to_decimal_ascii_top.sv =====
// Signed 32-bit integer to decimal ASCII text, most significant character first.
// Each divide by ten in the shared unit registers the product, then forms quotient and remainder.
// Output characters leave one per cycle unless char_stall holds them.
// Reset (rst, synchronous): return to idle and drop any pending character.
module signed_int_to_decimal_ascii_top (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                item_valid,
  output logic                item_stall,
  input  logic signed [31:0]  value,
  // output channel
  output logic                char_valid,
  input  logic                char_stall,
  output sidec_pkg::char_t    char_code,
  output logic                last
);
  import sidec_pkg::*;

  state_t      state;
  logic [31:0] mag;       // magnitude still to be divided
  logic        neg_pend;  // minus sign not yet sent
  digit_t      cnt;       // digit write pointer while dividing, read pointer while sending
  digit_t      digits [MAX_DIGITS];

  logic        item_beat;
  logic        out_free;
  logic        div_load;
  logic [31:0] quotient;
  digit_t      remainder;

  // Accept a new value only when idle; the output register may still hold
  // the previous value's last character.
  assign item_stall = rst || (state != ST_IDLE);
  assign item_beat  = item_valid && !item_stall;

  // Output register can take a new character this cycle.
  assign out_free = !char_valid || !char_stall;

  assign div_load = (state == ST_MUL);

  // Shared divide-by-ten unit: one digit per divide, least significant first.
  sidec_div10 u_div10 (
    .clk       (clk),
    .load      (div_load),
    .dividend  (mag),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      neg_pend   <= 1'b0;
      cnt        <= '0;
      char_valid <= 1'b0;
    end else begin
      // Drop the output beat once taken; while sending, ST_EMIT decides.
      if (char_valid && !char_stall && (state != ST_EMIT)) begin
        char_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_beat) begin
            neg_pend <= value[31];
            cnt      <= '0;
            state    <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          // Stop once the quotient is zero; cnt then points at the leading digit.
          if (quotient == 32'd0) begin
            state <= ST_EMIT;
          end else begin
            cnt   <= cnt + 4'd1;
            state <= ST_MUL;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            char_valid <= 1'b1;
            if (neg_pend) begin
              neg_pend <= 1'b0;
            end else if (cnt == 4'd0) begin
              state <= ST_IDLE;
            end else begin
              cnt <= cnt - 4'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload: magnitude, digit buffer and output character.
  always_ff @(posedge clk) begin
    if (item_beat) begin
      // Unsigned negate also covers the most negative value.
      mag <= value[31] ? (32'd0 - $unsigned(value)) : $unsigned(value);
    end else if (state == ST_DIV) begin
      mag <= quotient;
    end
    if (state == ST_DIV) begin
      digits[cnt] <= remainder;
    end
    if (state == ST_EMIT && out_free) begin
      if (neg_pend) begin
        char_code <= CHAR_MINUS;
        last      <= 1'b0;
      end else begin
        char_code <= CHAR_ZERO + {2'b00, digits[cnt]};
        last      <= (cnt == 4'd0);
      end
    end
  end

endmodule

// ===== src/sidec_check.sv =====
// Port-level checker for the decimal text converter, bound to the top level.
module sidec_check (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input logic             char_valid,
  input logic             char_stall,
  input sidec_pkg::char_t char_code,
  input logic             last
);
  import sidec_pkg::*;
  `include "signed_int_to_decimal_ascii_top_assert.svh"

  logic char_ok;

  assign char_ok = (char_code == CHAR_MINUS) ||
                   ((char_code >= CHAR_ZERO) && (char_code <= CHAR_ZERO + 6'd9));

  // Only a minus sign or a decimal digit leaves the block.
  `SIDEC_ASSERT_NOW(a_char_range, char_valid, char_ok)

  // A minus sign is always followed by at least one digit.
  `SIDEC_ASSERT_NOW(a_minus_not_last, char_valid && (char_code == CHAR_MINUS), !last)

  // An accepted value keeps the input closed for at least the next cycle.
  `SIDEC_ASSERT_NEXT(a_busy_after_beat, item_valid && !item_stall, item_stall)

  // A new value is never taken while a value's text is only partly sent.
  `SIDEC_ASSERT_NOW(a_no_overlap, char_valid && !last, item_stall)

  // A stalled character holds.
  `SIDEC_ASSERT_NEXT(a_out_hold, char_valid && char_stall, char_valid && $stable(char_code) && $stable(last))

endmodule

bind signed_int_to_decimal_ascii_top sidec_check u_sidec_check (.*);
